/* design/circular_deque_macros.svh */
// circular_deque_macros.svh: assertion macros shared by the deque rtl
// no dependencies; included inside module bodies after the package import
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CDQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cdq assertion failed");

// next-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cdq assertion failed");

`endif

/* design/cdq_pkg.sv */
// cdq_pkg: command codes, status codes, microcode word and control rom
// no dependencies; used by cdq_seq, cdq_dp and circular_deque
`default_nettype none

package cdq_pkg;

    localparam int CMD_W   = 3;
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = 5;
    localparam int UPC_W   = 4;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_ALL   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_FETCH     = 4'd0;
    localparam upc_t U_PUSH_CHK  = 4'd1;
    localparam upc_t U_PUSH_DO   = 4'd2;
    localparam upc_t U_POP_CHK   = 4'd3;
    localparam upc_t U_POP_DO    = 4'd4;
    localparam upc_t U_RD_INIT   = 4'd5;
    localparam upc_t U_RD_EMIT   = 4'd6;
    localparam upc_t U_REF_FULL  = 4'd7;
    localparam upc_t U_REF_EMPTY = 4'd8;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH,
        OP_PUSH,
        OP_POP_RD,
        OP_POP,
        OP_WALK_INIT,
        OP_WALK_STEP
    } op_t;

    typedef enum logic [2:0] {
        JC_FETCH,
        JC_NEXT,
        JC_GOTO,
        JC_IF_FULL,
        JC_IF_EMPTY,
        JC_LOOP_STOP
    } jc_t;

    typedef enum logic {
        DSEL_ZERO,
        DSEL_MEM
    } dsel_t;

    typedef enum logic {
        LSEL_ONE,
        LSEL_STOP
    } lsel_t;

    typedef struct packed {
        op_t             op;
        logic            emit;
        logic [ST_W-1:0] status;
        dsel_t           dsel;
        lsel_t           lsel;
        jc_t             jc;
        upc_t            target;
    } ucode_t;

    typedef struct packed {
        op_t             op;
        logic            load_out;
        logic [ST_W-1:0] status;
        dsel_t           dsel;
        lsel_t           lsel;
    } dp_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic stop;
        logic out_free;
    } dp_flags_t;

    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t w;
        w = '{op: OP_NOP, emit: 1'b0, status: ST_OK, dsel: DSEL_ZERO,
              lsel: LSEL_ONE, jc: JC_GOTO, target: U_FETCH};
        unique case (upc)
            U_FETCH: begin
                w.op = OP_LATCH;
                w.jc = JC_FETCH;
            end
            U_PUSH_CHK: begin
                w.jc     = JC_IF_FULL;
                w.target = U_REF_FULL;
            end
            U_PUSH_DO: begin
                w.op   = OP_PUSH;
                w.emit = 1'b1;
            end
            U_POP_CHK: begin
                w.op     = OP_POP_RD;
                w.jc     = JC_IF_EMPTY;
                w.target = U_REF_EMPTY;
            end
            U_POP_DO: begin
                w.op   = OP_POP;
                w.emit = 1'b1;
                w.dsel = DSEL_MEM;
            end
            U_RD_INIT: begin
                w.op     = OP_WALK_INIT;
                w.jc     = JC_IF_EMPTY;
                w.target = U_REF_EMPTY;
            end
            U_RD_EMIT: begin
                w.op   = OP_WALK_STEP;
                w.emit = 1'b1;
                w.dsel = DSEL_MEM;
                w.lsel = LSEL_STOP;
                w.jc   = JC_LOOP_STOP;
            end
            U_REF_FULL: begin
                w.emit   = 1'b1;
                w.status = ST_FULL;
            end
            U_REF_EMPTY: begin
                w.emit   = 1'b1;
                w.status = ST_EMPTY;
            end
            default: begin
                w.jc = JC_GOTO;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd);
        upc_t u;
        u = U_FETCH;
        case (cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_REAR: u = U_PUSH_CHK;
            CMD_POP_FRONT, CMD_POP_REAR:   u = U_POP_CHK;
            CMD_READ_ALL:                  u = U_RD_INIT;
            default:                       u = U_FETCH;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* design/cdq_seq.sv */
// cdq_seq: step counter, control rom lookup and conditional jumps
// depends on cdq_pkg; drives cdq_dp through a control struct
`default_nettype none

module cdq_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [cdq_pkg::CMD_W-1:0] s_cmd,
    input  wire cdq_pkg::dp_flags_t        flags,
    output cdq_pkg::dp_ctl_t               ctl
);
    import cdq_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t uw;
    logic   stall;
    logic   accept;

    assign uw     = ucode_rom(upc_reg);
    assign stall  = uw.emit && !flags.out_free;
    assign accept = (uw.jc == JC_FETCH) && s_valid;

    always_comb begin
        upc_next = upc_reg;
        unique case (uw.jc)
            JC_FETCH:     upc_next = s_valid ? dispatch(s_cmd) : upc_reg;
            JC_NEXT:      upc_next = upc_t'(upc_reg + 1'b1);
            JC_GOTO:      upc_next = uw.target;
            JC_IF_FULL:   upc_next = flags.full ? uw.target : upc_t'(upc_reg + 1'b1);
            JC_IF_EMPTY:  upc_next = flags.empty ? uw.target : upc_t'(upc_reg + 1'b1);
            JC_LOOP_STOP: upc_next = flags.stop ? uw.target : upc_reg;
            default:      upc_next = U_FETCH;
        endcase
        if (stall) begin
            upc_next = upc_reg;
        end
    end

    always_comb begin
        s_ready      = (uw.jc == JC_FETCH);
        ctl.op       = uw.op;
        if (stall || ((uw.jc == JC_FETCH) && !accept)) begin
            ctl.op = OP_NOP;
        end
        ctl.load_out = uw.emit && !stall;
        ctl.status   = uw.status;
        ctl.dsel     = uw.dsel;
        ctl.lsel     = uw.lsel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

/* design/cdq_dp.sv */
// cdq_dp: ring memory, front and rear indices, walk counter, result register
// depends on cdq_pkg and circular_deque_macros.svh; controlled by cdq_seq
`default_nettype none

module cdq_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic        [cdq_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic        [cdq_pkg::CMD_W-1:0]  s_cmd,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] s_value,
    input  wire cdq_pkg::dp_ctl_t                  ctl,
    output cdq_pkg::dp_flags_t                     flags,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic             [cdq_pkg::ST_W-1:0]   m_status,
    output logic signed      [cdq_pkg::DATA_W-1:0] m_data,
    output logic                                   m_last
);
    import cdq_pkg::*;
    `include "circular_deque_macros.svh"

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = ((IW > CFG_W) ? IW : CFG_W) + 1;

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]         cap_reg;
    logic [IW-1:0]            front_reg, front_next;
    logic [IW-1:0]            rear_reg, rear_next;
    logic                     empty_reg, empty_next;
    logic [IW-1:0]            ptr_reg, ptr_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rdata_reg;

    logic                     m_valid_reg;
    logic [ST_W-1:0]          m_status_reg;
    logic signed [DATA_W-1:0] m_data_reg;
    logic                     m_last_reg;

    logic [CMPW-1:0] cap_x, ec, ec_m1, lim;
    logic            is_rear, full, stop;
    logic            rd_en, wr_en;
    logic [IW-1:0]   raddr, waddr;

    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                               input logic [CMPW-1:0] top);
        logic [CMPW-1:0] ix;
        ix = CMPW'(i);
        return (ix >= top) ? '0 : IW'(ix + 1'b1);
    endfunction

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                               input logic [CMPW-1:0] top);
        return (i == '0) ? IW'(top) : IW'(i - 1'b1);
    endfunction

    always_comb begin
        cap_x = CMPW'(cap_reg);
        if (cap_reg == '0) begin
            ec = CMPW'(1);
        end else if (cap_x > CMPW'(DEPTH)) begin
            ec = CMPW'(DEPTH);
        end else begin
            ec = cap_x;
        end
        ec_m1 = ec - 1'b1;
        lim   = (ec > CMPW'(MAX_OUT)) ? CMPW'(MAX_OUT) : ec;
    end

    assign is_rear = (cmd_reg == CMD_PUSH_REAR) || (cmd_reg == CMD_POP_REAR);
    assign full    = !empty_reg &&
                     (((front_reg == '0) && (CMPW'(rear_reg) == ec_m1)) ||
                      ((CMPW'(rear_reg) + 1'b1) == CMPW'(front_reg)));
    assign stop    = (ptr_reg == rear_reg) || ((CMPW'(n_reg) + 1'b1) >= lim);

    assign flags.full     = full;
    assign flags.empty    = empty_reg;
    assign flags.stop     = stop;
    assign flags.out_free = !m_valid_reg || m_ready;

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        ptr_next   = ptr_reg;
        n_next     = n_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        raddr      = front_reg;
        waddr      = '0;
        unique case (ctl.op)
            OP_PUSH: begin
                wr_en = 1'b1;
                if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    waddr      = '0;
                end else if (is_rear) begin
                    rear_next = idx_next(rear_reg, ec_m1);
                    waddr     = rear_next;
                end else begin
                    front_next = idx_prev(front_reg, ec_m1);
                    waddr      = front_next;
                end
            end
            OP_POP_RD: begin
                rd_en = 1'b1;
                raddr = is_rear ? rear_reg : front_reg;
            end
            OP_POP: begin
                if (front_reg == rear_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end else if (is_rear) begin
                    rear_next = idx_prev(rear_reg, ec_m1);
                end else begin
                    front_next = idx_next(front_reg, ec_m1);
                end
            end
            OP_WALK_INIT: begin
                rd_en    = 1'b1;
                raddr    = front_reg;
                ptr_next = front_reg;
                n_next   = '0;
            end
            OP_WALK_STEP: begin
                rd_en    = 1'b1;
                ptr_next = idx_next(ptr_reg, ec_m1);
                raddr    = ptr_next;
                n_next   = CNT_W'(n_reg + 1'b1);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= value_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            front_reg   <= '0;
            rear_reg    <= '0;
            empty_reg   <= 1'b1;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            n_reg     <= n_next;
            if (ctl.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (ctl.op == OP_LATCH) begin
            cmd_reg   <= s_cmd;
            value_reg <= s_value;
        end
        if (ctl.load_out) begin
            m_status_reg <= ctl.status;
            m_data_reg   <= (ctl.dsel == DSEL_MEM) ? rdata_reg : '0;
            m_last_reg   <= (ctl.lsel == LSEL_ONE) ? 1'b1 : stop;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

    `CDQ_ASSERT_IMP(a_empty_idx_zero, aclk, aresetn, empty_reg, (front_reg == '0) && (rear_reg == '0))
    `CDQ_ASSERT_IMP(a_push_not_full, aclk, aresetn, ctl.op == OP_PUSH, !full)
    `CDQ_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, ctl.op == OP_POP, !empty_reg)
    `CDQ_ASSERT_NXT(a_walk_bounded, aclk, aresetn, ctl.op == OP_WALK_STEP, CMPW'(n_reg) <= lim)

endmodule

`default_nettype wire

/* design/circular_deque.sv */
// circular_deque: top level, microcoded deque over a ring memory
// depends on cdq_pkg, cdq_seq and cdq_dp
//
//   port group   dir   handshake          payload
//   cfg_wr_*     in    write enable only  cfg_wr_data (capacity)
//   s_*          in    s_valid / s_ready  s_cmd, s_value
//   m_*          out   m_valid / m_ready  m_status, m_data, m_last
//
// push, pop or refused command: fetch, check and do (or refuse) steps; the result
// register loads in the last step, after which the next transaction is accepted
// read-out: fetch and init steps, then emit steps that each load one result until
// the rear entry or output limit, then fetch again; the ring read is registered
// reset zeroes indices and step counter, sets the empty flag, loads capacity 16
// a result step holds while the output register is full and not taken
`default_nettype none

module circular_deque #(
    parameter int DEPTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic        [cdq_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [cdq_pkg::CMD_W-1:0]  s_cmd,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic             [cdq_pkg::ST_W-1:0]   m_status,
    output logic signed      [cdq_pkg::DATA_W-1:0] m_data,
    output logic                                   m_last
);
    import cdq_pkg::*;

    dp_ctl_t   ctl;
    dp_flags_t flags;

    cdq_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .flags   (flags),
        .ctl     (ctl)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .ctl         (ctl),
        .flags       (flags),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data      (m_data),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

/* bench/circular_deque_test.sv */
// circular_deque_test: self-checking bench for the ring-buffer deque, with a
// scoreboard class that predicts every response and random valid/ready traffic
// depends on cdq_pkg and circular_deque from the design folder
`default_nettype none

module circular_deque_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 41;
    localparam int REPORT_LIMIT = 10;
    localparam longint RUN_LIMIT_NS = 4_000_000;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_READ_ALL + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } deque_reply_t;

    class deque_scoreboard;
        deque_reply_t              due_replies[$];
        logic signed [DATA_W-1:0]  ring[RING_DEPTH];
        int                        front_pos;
        int                        rear_pos;
        bit                        is_empty;
        logic [CFG_W-1:0]          capacity;
        int                        errors;

        function new();
            front_pos = 0;
            rear_pos = 0;
            is_empty = 1'b1;
            capacity = CAP_RESET;
            errors = 0;
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] c);
            capacity = c;
        endfunction

        function int live_cap();
            if (capacity == 0) return 1;
            if (capacity > RING_DEPTH) return RING_DEPTH;
            return capacity;
        endfunction

        function int step_fwd(int i);
            return (i >= live_cap() - 1) ? 0 : i + 1;
        endfunction

        function int step_back(int i);
            return (i == 0) ? live_cap() - 1 : i - 1;
        endfunction

        function void add_reply(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] d, logic l);
            deque_reply_t r;
            r.status = st;
            r.data = d;
            r.last = l;
            due_replies.push_back(r);
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
            bit full;
            bit stop;
            int lim;
            int i;
            int n;
            logic signed [DATA_W-1:0] d;
            full = !is_empty && ((front_pos == 0 && rear_pos == live_cap() - 1) ||
                                 (rear_pos + 1 == front_pos));
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (full) begin
                        add_reply(ST_FULL, '0, 1'b1);
                    end else begin
                        if (is_empty) begin
                            front_pos = 0;
                            rear_pos = 0;
                            is_empty = 1'b0;
                            ring[0] = val;
                        end else if (cmd == CMD_PUSH_FRONT) begin
                            front_pos = step_back(front_pos);
                            ring[front_pos] = val;
                        end else begin
                            rear_pos = step_fwd(rear_pos);
                            ring[rear_pos] = val;
                        end
                        add_reply(ST_OK, '0, 1'b1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR: begin
                    if (is_empty) begin
                        add_reply(ST_EMPTY, '0, 1'b1);
                    end else begin
                        d = ring[(cmd == CMD_POP_FRONT) ? front_pos : rear_pos];
                        if (front_pos == rear_pos) begin
                            front_pos = 0;
                            rear_pos = 0;
                            is_empty = 1'b1;
                        end else if (cmd == CMD_POP_FRONT) begin
                            front_pos = step_fwd(front_pos);
                        end else begin
                            rear_pos = step_back(rear_pos);
                        end
                        add_reply(ST_OK, d, 1'b1);
                    end
                end
                CMD_READ_ALL: begin
                    if (is_empty) begin
                        add_reply(ST_EMPTY, '0, 1'b1);
                    end else begin
                        lim = (live_cap() > MAX_OUT) ? MAX_OUT : live_cap();
                        i = front_pos;
                        n = 0;
                        stop = 1'b0;
                        while (!stop) begin
                            stop = (i == rear_pos) || (n + 1 >= lim);
                            add_reply(ST_OK, ring[i], stop);
                            n++;
                            i = step_fwd(i);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] d, logic l);
            deque_reply_t exp_r;
            if (due_replies.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected transaction: status %0d data %0d last %0b", st, d, l);
                return;
            end
            exp_r = due_replies.pop_front();
            if (st !== exp_r.status || d !== exp_r.data || l !== exp_r.last) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected status %0d data %0d last %0b, got %0d %0d %0b",
                             exp_r.status, exp_r.data, exp_r.last, st, d, l);
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_W-1:0]         cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [ST_W-1:0]          m_status;
    logic signed [DATA_W-1:0] m_data;
    logic                     m_last;

    bit quiet;
    bit hold_req;
    deque_scoreboard sb;

    circular_deque #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_data(m_data),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_status, m_data, m_last);
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(cmd, val);
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] c);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= c;
        sb.set_capacity(c);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0]         cap_plan[8];
        logic signed [DATA_W-1:0] fill_words[16];
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
        int                       counted;
        int                       mode_left;
        bit                       filling;
        int                       pick;

        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_cmd = CMD_PUSH_FRONT;
        s_value = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        mode_left = 0;
        filling = 1'b1;
        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd16, 5'd0};
        cap_plan[7] = CFG_W'($urandom_range(15, 3));
        fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
                       32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe,
                       0, 0, 0, 0, 0, 0, 0, 0};
        for (int k = 8; k < 16; k++) fill_words[k] = $urandom;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // refused and ignored commands on an empty deque
        send_item(CMD_POP_FRONT, 32'h1234_5678);
        send_item(CMD_POP_REAR, '0);
        send_item(CMD_READ_ALL, '0);
        send_item(CMD_SPARE_LO, $urandom);
        send_item(CMD_SPARE_HI, $urandom);
        // fill the whole ring so no entry stays unwritten
        for (int k = 0; k < RING_DEPTH; k++) send_item(CMD_PUSH_REAR, fill_words[k]);
        send_item(CMD_PUSH_FRONT, $urandom);
        send_item(CMD_PUSH_REAR, $urandom);
        send_item(CMD_READ_ALL, '0);
        send_item(CMD_POP_FRONT, '0);
        send_item(CMD_POP_REAR, '0);
        send_item(CMD_PUSH_FRONT, 32'h8000_0000);
        send_item(CMD_PUSH_FRONT, 32'h7fff_ffff);

        for (int phase = 0; phase < 8; phase++) begin
            drain_and_settle();
            write_capacity(cap_plan[phase]);
            quiet = (phase == 6);
            if (phase == 2) hold_req = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (mode_left == 0) begin
                    filling = 1'($urandom_range(1));
                    mode_left = $urandom_range(24, 8);
                end
                mode_left--;
                pick = $urandom_range(99);
                if (pick < 5)
                    cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                else if (pick < 15)
                    cmd = CMD_READ_ALL;
                else if ((pick < 70) == filling)
                    cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
                else
                    cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
                case ($urandom_range(11))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7fff_ffff;
                    2: val = '1;
                    3: val = '0;
                    default: val = $urandom;
                endcase
                send_item(cmd, val);
                if (cmd <= CMD_READ_ALL) counted++;
            end
        end

        quiet = 1'b0;
        drain_and_settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
